[src/ddo_pkg.sv]
// shared types, constants and tables for the differential drive odometry integrator
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

   // iteration count of the heading cordic, 12 to 32
   localparam int CORDIC_STEPS = 24;
   localparam int ATAN_DEPTH   = 32;
   localparam int ATAN_IDX_W   = $clog2(ATAN_DEPTH);

   // datapath width of the cordic and of the shared multiplier operands
   localparam int CW = 34;
   localparam int PW = 2 * CW;

   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [29:0]          RAD_TO_BAM  = 30'd683565276;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_SPEED_LEFT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_SPEED_RIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_TURN_LEFT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_TURN_RIGHT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECONDS_PER_TICK = 3'd4;

   localparam logic signed [31:0] GAIN_SPEED_RESET      = 32'sd10820;
   localparam logic signed [31:0] GAIN_TURN_LEFT_RESET  = 32'sd60855;
   localparam logic signed [31:0] GAIN_TURN_RIGHT_RESET = -32'sd60855;
   localparam logic [31:0]        SECONDS_PER_TICK_RESET = 32'd4295;

   typedef struct packed {
      logic signed [23:0] speed_front_left;
      logic signed [23:0] speed_front_right;
      logic signed [23:0] speed_rear_left;
      logic signed [23:0] speed_rear_right;
      logic [47:0]        stamp_front_left;
      logic [47:0]        stamp_front_right;
      logic [47:0]        stamp_rear_left;
      logic [47:0]        stamp_rear_right;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        heading_angle;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] yaw_rate;
      logic               time_error;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] gain_speed_left;
      logic signed [31:0] gain_speed_right;
      logic signed [31:0] gain_turn_left;
      logic signed [31:0] gain_turn_right;
      logic [31:0]        seconds_per_tick;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic signed [24:0] sum_left;
      logic signed [24:0] sum_right;
      logic [47:0]        diff;
      logic               time_error;
   } item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic                 done;
      logic signed [CW-1:0] cos_val;
      logic signed [CW-1:0] sin_val;
   } cordic_out_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DTL, ST_DTH, ST_VL, ST_VR, ST_WL, ST_WR, ST_WF,
      ST_HL, ST_HH, ST_HF, ST_KL, ST_KH, ST_KF, ST_WAIT,
      ST_CX, ST_CY, ST_XL, ST_XH, ST_XF, ST_XI, ST_YL, ST_YH, ST_YF, ST_YI,
      ST_OUT
   } back_state_type;

   // atan(2^-i) as binary angle
   function automatic logic [31:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[src/ddo_front.sv]
// front end: takes items, builds side sums and earliest stamp, classifies the time step
`timescale 1ns / 1ps
`default_nettype none

module ddo_front import ddo_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   input  wire queue_status_type q_status,
   output logic                  push,
   output item_type              push_data
);

   logic               stage_valid_ff, stage_valid_in;
   logic signed [24:0] sum_left_ff, sum_left_in;
   logic signed [24:0] sum_right_ff, sum_right_in;
   logic [47:0]        tmin_ff, tmin_in;
   logic [47:0]        last_stamp_ff, last_stamp_in;
   logic               primed_ff, primed_in;

   logic        accept;
   logic [47:0] min_front, min_rear;

   assign push      = stage_valid_ff && !q_status.full;
   assign req_stall = stage_valid_ff && !push;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      min_front = (req_data.stamp_front_right < req_data.stamp_front_left) ?
                  req_data.stamp_front_right : req_data.stamp_front_left;
      min_rear  = (req_data.stamp_rear_right < req_data.stamp_rear_left) ?
                  req_data.stamp_rear_right : req_data.stamp_rear_left;
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      sum_left_in    = sum_left_ff;
      sum_right_in   = sum_right_ff;
      tmin_in        = tmin_ff;
      if (push) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in = 1'b1;
         sum_left_in    = 25'(req_data.speed_front_left) + 25'(req_data.speed_rear_left);
         sum_right_in   = 25'(req_data.speed_front_right) + 25'(req_data.speed_rear_right);
         tmin_in        = (min_rear < min_front) ? min_rear : min_front;
      end
   end

   // time step classification
   always_comb begin
      push_data.sum_left   = sum_left_ff;
      push_data.sum_right  = sum_right_ff;
      push_data.diff       = '0;
      push_data.time_error = 1'b0;
      if (primed_ff) begin
         if (tmin_ff <= last_stamp_ff) begin
            push_data.time_error = 1'b1;
         end else begin
            push_data.diff = tmin_ff - last_stamp_ff;
         end
      end
      last_stamp_in = push ? tmin_ff : last_stamp_ff;
      primed_in     = push ? 1'b1 : primed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         last_stamp_ff  <= '0;
         primed_ff      <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         last_stamp_ff  <= last_stamp_in;
         primed_ff      <= primed_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_left_ff  <= sum_left_in;
      sum_right_ff <= sum_right_in;
      tmin_ff      <= tmin_in;
   end

endmodule

`default_nettype wire

[src/ddo_queue.sv]
// short queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none

module ddo_queue import ddo_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire item_type   push_data,
   input  wire logic       pop,
   output item_type        head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head             = mem_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/ddo_cordic.sv]
// iterative cordic giving cosine and sine of a binary angle, one rotation per cycle
`timescale 1ns / 1ps
`default_nettype none

module ddo_cordic import ddo_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] angle,
   output cordic_out_type   result
);

   localparam logic [ATAN_IDX_W-1:0] LAST_IDX = ATAN_IDX_W'(CORDIC_STEPS - 1);

   logic signed [CW-1:0]  x_ff, x_in;
   logic signed [CW-1:0]  y_ff, y_in;
   logic signed [CW-1:0]  z_ff, z_in;
   logic [1:0]            quad_ff, quad_in;
   logic [ATAN_IDX_W-1:0] idx_ff, idx_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic signed [CW-1:0] dx, dy, step_angle;

   always_comb begin
      dx         = y_ff >>> idx_ff;
      dy         = x_ff >>> idx_ff;
      step_angle = $signed({{(CW-32){1'b0}}, atan_bam(idx_ff)});
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = $signed({{(CW-30){1'b0}}, angle[29:0]});
         quad_in = angle[31:30];
         idx_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!z_ff[CW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step_angle;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step_angle;
         end
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      idx_ff  <= idx_in;
   end

   // map the first-quadrant result back to the full circle
   always_comb begin
      result.done = done_ff;
      case (quad_ff)
         2'd0: begin
            result.cos_val = x_ff;
            result.sin_val = y_ff;
         end
         2'd1: begin
            result.cos_val = -y_ff;
            result.sin_val = x_ff;
         end
         2'd2: begin
            result.cos_val = -x_ff;
            result.sin_val = -y_ff;
         end
         default: begin
            result.cos_val = y_ff;
            result.sin_val = -x_ff;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/ddo_back.sv]
// back end: sequencer over a shared multiplier and the cordic, integrates the pose
`timescale 1ns / 1ps
`default_nettype none

module ddo_back import ddo_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire queue_status_type q_status,
   input  wire item_type         q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   localparam logic signed [69:0] SAT_MAX = 70'sd2147483647;
   localparam logic signed [69:0] SAT_MIN = -70'sd2147483648;

   back_state_type state_ff, state_in;

   item_type             item_ff, item_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic [47:0]          dt_ff, dt_in;
   logic [55:0]          hinc_ff, hinc_in;
   logic [47:0]          q_ff, q_in;
   logic signed [31:0]   v_ff, v_in;
   logic signed [31:0]   w_ff, w_in;
   logic signed [31:0]   vx_ff, vx_in;
   logic signed [31:0]   vy_ff, vy_in;
   logic signed [31:0]   x_ff, x_in;
   logic signed [31:0]   y_ff, y_in;
   logic [31:0]          heading_ff, heading_in;

   logic signed [CW-1:0] mul_a, mul_b;
   logic                 cor_start;
   cordic_out_type       cor;

   logic [79:0]        wide_sum, hmag_sum, q_sum;
   logic [55:0]        hmag, head_sum;
   logic signed [69:0] gain_sum, gain_round, rot_round, q_signed, x_sum, y_sum;
   logic [31:0]        w_mag, vx_mag, vy_mag;

   function automatic logic signed [31:0] sat32(input logic signed [69:0] val);
      logic signed [31:0] r;
      if (val > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (val < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = val[31:0];
      end
      return r;
   endfunction

   ddo_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cor_start),
      .angle  (heading_ff),
      .result (cor)
   );

   // shared arithmetic on the registered product
   always_comb begin
      wide_sum   = {24'd0, acc_ff[55:0]} + {prod_ff[55:0], 24'd0};
      hmag_sum   = wide_sum + (80'd1 << 23);
      hmag       = hmag_sum[79:24];
      q_sum      = wide_sum + (80'd1 << 31);
      gain_sum   = 70'(acc_ff) + 70'(prod_ff) + 70'sd65536;
      gain_round = gain_sum >>> 17;
      rot_round  = (70'(prod_ff) + 70'sd536870912) >>> 30;
      head_sum   = acc_ff[55:0] + {prod_ff[27:0], 28'd0} + (56'd1 << 23);
      q_signed   = $signed({22'd0, q_ff});
      x_sum      = 70'(x_ff) + (vx_ff[31] ? -q_signed : q_signed);
      y_sum      = 70'(y_ff) + (vy_ff[31] ? -q_signed : q_signed);
      w_mag      = w_ff[31] ? (~w_ff + 32'd1) : w_ff;
      vx_mag     = vx_ff[31] ? (~vx_ff + 32'd1) : vx_ff;
      vy_mag     = vy_ff[31] ? (~vy_ff + 32'd1) : vy_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (q_status.not_empty) state_in = ST_DTL;
         ST_DTL:  state_in = ST_DTH;
         ST_DTH:  state_in = ST_VL;
         ST_VL:   state_in = ST_VR;
         ST_VR:   state_in = ST_WL;
         ST_WL:   state_in = ST_WR;
         ST_WR:   state_in = ST_WF;
         ST_WF:   state_in = ST_HL;
         ST_HL:   state_in = ST_HH;
         ST_HH:   state_in = ST_HF;
         ST_HF:   state_in = ST_KL;
         ST_KL:   state_in = ST_KH;
         ST_KH:   state_in = ST_KF;
         ST_KF:   state_in = ST_WAIT;
         ST_WAIT: if (cor.done) state_in = ST_CX;
         ST_CX:   state_in = ST_CY;
         ST_CY:   state_in = ST_XL;
         ST_XL:   state_in = ST_XH;
         ST_XH:   state_in = ST_XF;
         ST_XF:   state_in = ST_XI;
         ST_XI:   state_in = ST_YL;
         ST_YL:   state_in = ST_YH;
         ST_YH:   state_in = ST_YF;
         ST_YF:   state_in = ST_YI;
         ST_YI:   state_in = ST_OUT;
         ST_OUT:  if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs and multiplier operands
   always_comb begin
      q_pop     = 1'b0;
      cor_start = 1'b0;
      rsp_valid = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            q_pop     = q_status.not_empty;
            cor_start = q_status.not_empty;
         end
         ST_DTL: begin
            mul_a = $signed({{(CW-24){1'b0}}, item_ff.diff[23:0]});
            mul_b = $signed({{(CW-32){1'b0}}, cfg.seconds_per_tick});
         end
         ST_DTH: begin
            mul_a = $signed({{(CW-24){1'b0}}, item_ff.diff[47:24]});
            mul_b = $signed({{(CW-32){1'b0}}, cfg.seconds_per_tick});
         end
         ST_VL: begin
            mul_a = CW'(cfg.gain_speed_left);
            mul_b = CW'(item_ff.sum_left);
         end
         ST_VR: begin
            mul_a = CW'(cfg.gain_speed_right);
            mul_b = CW'(item_ff.sum_right);
         end
         ST_WL: begin
            mul_a = CW'(cfg.gain_turn_left);
            mul_b = CW'(item_ff.sum_left);
         end
         ST_WR: begin
            mul_a = CW'(cfg.gain_turn_right);
            mul_b = CW'(item_ff.sum_right);
         end
         ST_HL, ST_HH: begin
            mul_a = $signed({{(CW-32){1'b0}}, w_mag});
            mul_b = (state_ff == ST_HL) ? $signed({{(CW-24){1'b0}}, dt_ff[23:0]})
                                        : $signed({{(CW-24){1'b0}}, dt_ff[47:24]});
         end
         ST_KL: begin
            mul_a = $signed({{(CW-28){1'b0}}, hinc_ff[27:0]});
            mul_b = $signed({{(CW-30){1'b0}}, RAD_TO_BAM});
         end
         ST_KH: begin
            mul_a = $signed({{(CW-28){1'b0}}, hinc_ff[55:28]});
            mul_b = $signed({{(CW-30){1'b0}}, RAD_TO_BAM});
         end
         ST_CX: begin
            mul_a = CW'(v_ff);
            mul_b = cor.cos_val;
         end
         ST_CY: begin
            mul_a = CW'(v_ff);
            mul_b = cor.sin_val;
         end
         ST_XL, ST_XH: begin
            mul_a = $signed({{(CW-32){1'b0}}, vx_mag});
            mul_b = (state_ff == ST_XL) ? $signed({{(CW-24){1'b0}}, dt_ff[23:0]})
                                        : $signed({{(CW-24){1'b0}}, dt_ff[47:24]});
         end
         ST_YL, ST_YH: begin
            mul_a = $signed({{(CW-32){1'b0}}, vy_mag});
            mul_b = (state_ff == ST_YL) ? $signed({{(CW-24){1'b0}}, dt_ff[23:0]})
                                        : $signed({{(CW-24){1'b0}}, dt_ff[47:24]});
         end
         ST_OUT: rsp_valid = 1'b1;
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // datapath register updates, each step folds in the previous product
   always_comb begin
      prod_in    = mul_a * mul_b;
      item_in    = item_ff;
      acc_in     = acc_ff;
      dt_in      = dt_ff;
      hinc_in    = hinc_ff;
      q_in       = q_ff;
      v_in       = v_ff;
      w_in       = w_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      heading_in = heading_ff;
      case (state_ff)
         ST_IDLE: if (q_status.not_empty) item_in = q_head;
         ST_DTH, ST_VR, ST_WR, ST_HH, ST_KH, ST_XH, ST_YH: acc_in = prod_ff;
         ST_VL: dt_in = (|wide_sum[79:48]) ? '1 : wide_sum[47:0];
         ST_WL: v_in = sat32(gain_round);
         ST_WF: w_in = sat32(gain_round);
         ST_HF: hinc_in = w_ff[31] ? (~hmag + 56'd1) : hmag;
         ST_KF: heading_in = heading_ff + head_sum[55:24];
         ST_CY: vx_in = sat32(rot_round);
         ST_XL: vy_in = sat32(rot_round);
         ST_XF, ST_YF: q_in = q_sum[79:32];
         ST_XI: x_in = sat32(x_sum);
         ST_YI: y_in = sat32(y_sum);
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         x_ff       <= '0;
         y_ff       <= '0;
         heading_ff <= '0;
         vx_ff      <= '0;
         vy_ff      <= '0;
         w_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         heading_ff <= heading_in;
         vx_ff      <= vx_in;
         vy_ff      <= vy_in;
         w_ff       <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      dt_ff   <= dt_in;
      hinc_ff <= hinc_in;
      q_ff    <= q_in;
      v_ff    <= v_in;
   end

   always_comb begin
      rsp_data.pos_x         = x_ff;
      rsp_data.pos_y         = y_ff;
      rsp_data.heading_angle = heading_ff;
      rsp_data.vel_x         = vx_ff;
      rsp_data.vel_y         = vy_ff;
      rsp_data.yaw_rate      = w_ff;
      rsp_data.time_error    = item_ff.time_error;
   end

   // rotation must never start before the cordic has finished
   a_cordic_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CX) |-> cor.done)
      else $error("rotation step entered with cordic still running");

   // a flagged time step integrates over zero time
   a_error_zero_dt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HL && item_ff.time_error) |-> (dt_ff == '0))
      else $error("time error with nonzero dt");

   // the queue is drained only when it holds an item
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.not_empty)
      else $error("pop from empty queue");

   // the heading moves only in its update step
   a_heading_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_KF) |=> $stable(heading_ff))
      else $error("heading changed outside its update step");

endmodule

`default_nettype wire

[src/diff_drive_odometry_integrator_top.sv]
// top level of the differential drive odometry integrator with its register file
`timescale 1ns / 1ps
`default_nettype none

// Differential drive odometry: each item gives four wheel speeds and stamps and yields
// one pose result (position, heading, world velocity, yaw rate, time error flag).
// The back end takes a new item only after the result of the last one has left
// ST_OUT, never while it waits on rsp_stall: the iterative cordic, one rotation per
// cycle, runs beside the gain and heading steps and is followed by ten sequencer
// steps around the shared multiplier for the rotated velocity and the position update.
// The front end classifies each item from a holding register and keeps up to two of
// them in a queue, so inputs are taken while a result waits on rsp_stall. Registers
// are written through the csr port, which is always ready; write them only while the block is idle.

module diff_drive_odometry_integrator_top import ddo_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_data
);

   cfg_type          cfg_ff, cfg_in;
   logic             push, pop;
   item_type         push_data, head;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAIN_SPEED_LEFT:  cfg_in.gain_speed_left  = csr_data;
            CSR_GAIN_SPEED_RIGHT: cfg_in.gain_speed_right = csr_data;
            CSR_GAIN_TURN_LEFT:   cfg_in.gain_turn_left   = csr_data;
            CSR_GAIN_TURN_RIGHT:  cfg_in.gain_turn_right  = csr_data;
            CSR_SECONDS_PER_TICK: cfg_in.seconds_per_tick = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_speed_left  <= GAIN_SPEED_RESET;
         cfg_ff.gain_speed_right <= GAIN_SPEED_RESET;
         cfg_ff.gain_turn_left   <= GAIN_TURN_LEFT_RESET;
         cfg_ff.gain_turn_right  <= GAIN_TURN_RIGHT_RESET;
         cfg_ff.seconds_per_tick <= SECONDS_PER_TICK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ddo_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   ddo_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   ddo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_head    (head),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
